>>> hw/rtl/wnpip_pkg.sv
// ----------------------------------------------------------------------------
// wnpip_pkg
// Shared widths, command and status codes, and the control and status
// bundles between the sequencer and the edge unit.
// ----------------------------------------------------------------------------
package wnpip_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned WIND_W  = 9;
  localparam int unsigned STAT_W  = 2;

  // Edge arithmetic widths: coordinate difference and exact product
  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;

  // Default vertex capacity
  localparam int unsigned MAX_VERT_DEFAULT = 256;

  // Winding output clamp
  localparam int WIND_MAX = 255;
  localparam int WIND_MIN = -256;

  // Commands
  localparam logic [CMD_W-1:0] CMD_NEW    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;

  // Result status
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OVF   = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  // Sequencer -> edge unit
  typedef struct packed {
    logic load_pt;    // capture test point
    logic load_prev;  // capture current vertex as edge start
    logic load_diff;  // register edge differences and crossing flags
    logic mul_ab;     // product one: (x1-x0)*(py-y0)
    logic mul_cd;     // product two: (px-x0)*(y1-y0)
  } edge_ctl_t;

  // Edge unit -> sequencer
  typedef struct packed {
    logic up;  // upward crossing
    logic dn;  // downward crossing
    logic gt;  // cross product positive
    logic lt;  // cross product negative
  } edge_sts_t;

endpackage

>>> hw/rtl/wnpip_in_if.sv
// ----------------------------------------------------------------------------
// wnpip_in_if
// Input channel: vertex loads and test points.
// ----------------------------------------------------------------------------
interface wnpip_in_if
  import wnpip_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic [ID_W-1:0]           point_id;

  modport source (output valid, cmd, coord_x, coord_y, point_id, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, point_id, output ready);
endinterface

>>> hw/rtl/wnpip_out_if.sv
// ----------------------------------------------------------------------------
// wnpip_out_if
// Result channel: one beat per test point.
// ----------------------------------------------------------------------------
interface wnpip_out_if
  import wnpip_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [ID_W-1:0]          result_id;
  logic signed [WIND_W-1:0] winding;
  logic                     inside_res;
  logic [STAT_W-1:0]        status;

  modport source (output valid, result_id, winding, inside_res, status, input ready);
  modport sink   (input valid, result_id, winding, inside_res, status, output ready);
endinterface

>>> hw/rtl/wnpip_ram.sv
// ----------------------------------------------------------------------------
// wnpip_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wnpip_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/wnpip_edge.sv
// ----------------------------------------------------------------------------
// wnpip_edge
// Edge unit: edge differences, one shared 33x33 signed multiplier used
// twice per edge, and the exact sign of the cross product.
// ----------------------------------------------------------------------------
module wnpip_edge
  import wnpip_pkg::*;
(
  input  logic                      clk_i,
  input  edge_ctl_t                 ctl_i,
  input  logic signed [COORD_W-1:0] pt_x_i,
  input  logic signed [COORD_W-1:0] pt_y_i,
  input  logic signed [COORD_W-1:0] vtx_x_i,
  input  logic signed [COORD_W-1:0] vtx_y_i,
  output edge_sts_t                 sts_o
);

  logic signed [COORD_W-1:0] pt_x_q, pt_y_q;
  logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
  logic signed [DIFF_W-1:0]  a_q, b_q, c_q, d_q;
  logic signed [DIFF_W-1:0]  a_d, b_d, c_d, d_d;
  logic                      up_q, dn_q, up_d, dn_d;
  logic signed [DIFF_W-1:0]  op_l, op_r;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  p1_q, p2_q;
  logic [PROD_W:0]           cross_diff;

  // Edge from prev vertex (x0,y0) to current vertex (x1,y1)
  always_comb begin
    a_d  = {vtx_x_i[COORD_W-1], vtx_x_i} - {prev_x_q[COORD_W-1], prev_x_q};
    b_d  = {pt_y_q[COORD_W-1], pt_y_q} - {prev_y_q[COORD_W-1], prev_y_q};
    c_d  = {pt_x_q[COORD_W-1], pt_x_q} - {prev_x_q[COORD_W-1], prev_x_q};
    d_d  = {vtx_y_i[COORD_W-1], vtx_y_i} - {prev_y_q[COORD_W-1], prev_y_q};
    up_d = (prev_y_q <= pt_y_q) && (vtx_y_i > pt_y_q);
    dn_d = (prev_y_q > pt_y_q) && (vtx_y_i <= pt_y_q);
  end

  // Shared multiplier
  assign op_l = ctl_i.mul_cd ? c_q : a_q;
  assign op_r = ctl_i.mul_cd ? d_q : b_q;
  assign prod = op_l * op_r;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_pt) begin
      pt_x_q <= pt_x_i;
      pt_y_q <= pt_y_i;
    end
    if (ctl_i.load_diff) begin
      a_q  <= a_d;
      b_q  <= b_d;
      c_q  <= c_d;
      d_q  <= d_d;
      up_q <= up_d;
      dn_q <= dn_d;
    end
    if (ctl_i.load_prev) begin
      prev_x_q <= vtx_x_i;
      prev_y_q <= vtx_y_i;
    end
    if (ctl_i.mul_ab) begin
      p1_q <= prod;
    end
    if (ctl_i.mul_cd) begin
      p2_q <= prod;
    end
  end

  // Sign of p1 - p2, one bit wider so it cannot wrap
  assign cross_diff = {p1_q[PROD_W-1], p1_q} - {p2_q[PROD_W-1], p2_q};

  always_comb begin
    sts_o.up = up_q;
    sts_o.dn = dn_q;
    sts_o.lt = cross_diff[PROD_W];
    sts_o.gt = !cross_diff[PROD_W] && (|cross_diff);
  end

endmodule

>>> hw/rtl/winding_number_point_in_polygon_top.sv
// ----------------------------------------------------------------------------
// winding_number_point_in_polygon_top
// Winding-number point-in-polygon test over a stored polygon.
//
//   channel  dir  beat contents
//   in_i     in   cmd, coord_x, coord_y, point_id (vertex load or test point)
//   out_o    out  result_id, winding, inside_res, status (one per test point)
//
// A vertex beat leaves the block in idle, so it stays ready for the next beat.
// A test point over N stored vertices is walked edge by edge up to the result
// register (an empty polygon goes straight there): every edge uses the
// one shared 33x33 multiplier twice, after one vertex memory read.
// The input is not ready while a test point is walked, nor while a finished
// result waits for an output register that is still held by a stalled beat.
// Reset clears the vertex count and overflow flag; the vertex memory is not
// cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module winding_number_point_in_polygon_top
  import wnpip_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERT_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wnpip_in_if.sink          in_i,
  wnpip_out_if.source       out_o
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned EW = (WW > WIND_W + 1) ? WW : WIND_W + 1;
  localparam logic signed [EW-1:0] WN_HI = EW'(WIND_MAX);
  localparam logic signed [EW-1:0] WN_LO = EW'(WIND_MIN);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIRST = 3'd1;
  localparam logic [2:0] S_DIFF  = 3'd2;
  localparam logic [2:0] S_MUL1  = 3'd3;
  localparam logic [2:0] S_MUL2  = 3'd4;
  localparam logic [2:0] S_CMP   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 ovf_q, ovf_d;
  logic [CW-1:0]        rd_idx_q, rd_idx_d;
  logic                 wrap_q, wrap_d;
  logic                 pend_q, pend_d;
  logic signed [WW-1:0] wn_q, wn_d;
  logic [ID_W-1:0]      id_q;

  logic                 out_valid_q, out_valid_d;
  logic [ID_W-1:0]      res_id_q;
  logic signed [WIND_W-1:0] wind_q, wind_d;
  logic                 inside_q, inside_d;
  logic [STAT_W-1:0]    status_q, status_d;
  logic                 out_load;

  logic                 accept;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [2*COORD_W-1:0] ram_rdata;
  logic                 rd_wrap;
  logic signed [EW-1:0] wn_ext;
  edge_ctl_t            ctl;
  edge_sts_t            sts;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // Vertex memory, x in the upper half, y in the lower half
  wnpip_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_VERTICES)
  ) u_vtx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_i.coord_x, in_i.coord_y}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wnpip_edge u_edge (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .pt_x_i  (in_i.coord_x),
    .pt_y_i  (in_i.coord_y),
    .vtx_x_i (ram_rdata[2*COORD_W-1:COORD_W]),
    .vtx_y_i (ram_rdata[COORD_W-1:0]),
    .sts_o   (sts)
  );

  // Read address: vertex 0 at start and for the closing edge
  assign rd_wrap   = (rd_idx_q == cnt_q);
  assign ram_raddr = ((state_q == S_IDLE) || rd_wrap) ? '0 : rd_idx_q[AW-1:0];

  // Final winding, clamped to the output range
  assign wn_ext = EW'(wn_q);

  always_comb begin
    if (wn_ext > WN_HI) begin
      wind_d = WN_HI[WIND_W-1:0];
    end else if (wn_ext < WN_LO) begin
      wind_d = WN_LO[WIND_W-1:0];
    end else begin
      wind_d = wn_ext[WIND_W-1:0];
    end
    inside_d = (wn_q != '0);
    if (cnt_q == '0) begin
      status_d = STATUS_EMPTY;
    end else if (ovf_q) begin
      status_d = STATUS_OVF;
    end else begin
      status_d = STATUS_OK;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    rd_idx_d  = rd_idx_q;
    wrap_d    = wrap_q;
    pend_d    = pend_q;
    wn_d      = wn_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_re    = 1'b0;
    out_load  = 1'b0;
    ctl       = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.cmd)
            CMD_NEW: begin
              ram_we = 1'b1;
              cnt_d  = CW'(1);
              ovf_d  = 1'b0;
            end
            CMD_APPEND: begin
              if (cnt_q < CW'(MAX_VERTICES)) begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[AW-1:0];
                cnt_d     = cnt_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            CMD_TEST: begin
              ctl.load_pt = 1'b1;
              wn_d        = '0;
              pend_d      = 1'b0;
              wrap_d      = 1'b0;
              if (cnt_q == '0) begin
                state_d = S_DONE;
              end else begin
                ram_re   = 1'b1;
                rd_idx_d = CW'(1);
                state_d  = S_FIRST;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIRST: begin
        ctl.load_prev = 1'b1;
        ram_re        = 1'b1;
        wrap_d        = rd_wrap;
        if (!rd_wrap) begin
          rd_idx_d = rd_idx_q + CW'(1);
        end
        state_d = S_DIFF;
      end
      S_DIFF: begin
        // settle the previous edge while this one is registered
        if (pend_q) begin
          if (sts.up && sts.gt) begin
            wn_d = wn_q + WW'(1);
          end else if (sts.dn && sts.lt) begin
            wn_d = wn_q - WW'(1);
          end
        end
        ctl.load_diff = 1'b1;
        ctl.load_prev = 1'b1;
        state_d       = S_MUL1;
      end
      S_MUL1: begin
        ctl.mul_ab = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        ctl.mul_cd = 1'b1;
        pend_d     = 1'b1;
        if (wrap_q) begin
          state_d = S_CMP;
        end else begin
          ram_re = 1'b1;
          wrap_d = rd_wrap;
          if (!rd_wrap) begin
            rd_idx_d = rd_idx_q + CW'(1);
          end
          state_d = S_DIFF;
        end
      end
      S_CMP: begin
        if (sts.up && sts.gt) begin
          wn_d = wn_q + WW'(1);
        end else if (sts.dn && sts.lt) begin
          wn_d = wn_q - WW'(1);
        end
        pend_d  = 1'b0;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      rd_idx_q    <= '0;
      wrap_q      <= 1'b0;
      pend_q      <= 1'b0;
      wn_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      rd_idx_q    <= rd_idx_d;
      wrap_q      <= wrap_d;
      pend_q      <= pend_d;
      wn_q        <= wn_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept && (in_i.cmd == CMD_TEST)) begin
      id_q <= in_i.point_id;
    end
    if (out_load) begin
      res_id_q <= id_q;
      wind_q   <= wind_d;
      inside_q <= inside_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.result_id  = res_id_q;
  assign out_o.winding    = wind_q;
  assign out_o.inside_res = inside_q;
  assign out_o.status     = status_q;

`ifndef SYNTHESIS
  // A new polygon always leaves exactly one vertex
  a_new_poly_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.cmd == CMD_NEW)) |=> (cnt_q == CW'(1)))
    else $error("vertex count not one after new polygon");

  // A test point over a nonempty polygon starts the edge walk
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.cmd == CMD_TEST) && (cnt_q != '0)) |=> (state_q == S_FIRST))
    else $error("edge walk did not start");

  // A waiting result is never overwritten while the output beat is stalled
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && out_valid_q && !out_o.ready) |=> (state_q == S_DONE))
    else $error("result overwritten under stall");

  // The closing edge read is only marked once the index reached the count
  a_wrap_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wrap_q && ((state_q == S_DIFF) || (state_q == S_MUL1) || (state_q == S_MUL2)))
      |-> (rd_idx_q == cnt_q))
    else $error("closing edge marked early");
`endif

endmodule
